[hw/rtl/hfts_pkg.sv]
// ----------------------------------------------------------------------------
// Hot field top-3 selector package
// Shared constants, register indexes and word types for the selector.
// ----------------------------------------------------------------------------
package hfts_pkg;

  localparam int HF_CLASSES  = 256;
  localparam int QUEUE_DEPTH = 2;
  localparam int CLASS_W     = 8;
  localparam int MAX_TABLE   = 2 ** CLASS_W;

  localparam logic [7:0]  NO_FIELD          = 8'hFF;
  localparam logic [7:0]  PERMANENT         = 8'hFF;
  localparam logic [63:0] MIN_THIRD_HOTNESS = 64'd50000;

  localparam logic [1:0] MODE_TWO   = 2'd2;
  localparam logic [1:0] MODE_THREE = 2'd3;

  typedef enum logic [1:0] {
    REG_MIN_CPU_USE     = 2'd0,
    REG_PATH_MODE       = 2'd1,
    REG_ALLOW_PERMANENT = 2'd2,
    REG_MAX_REPEATS     = 2'd3
  } cfg_reg_t;

  typedef logic [2:0][7:0]  offs_t;
  typedef logic [2:0][63:0] hot3_t;

  typedef struct packed {
    offs_t      offs;
    logic [7:0] repeats;
  } entry_t;

  typedef struct packed {
    logic [CLASS_W-1:0] class_index;
    logic [7:0]         field_offset;
    logic [63:0]        hotness;
    logic               consider;
    logic               first_record;
    logic               last_record;
  } item_t;

  typedef struct packed {
    logic [1:0] path_mode;
    logic       allow_permanent;
    logic [7:0] max_repeats;
  } back_cfg_t;

endpackage

[hw/rtl/hfts_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module hfts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/hfts_front.sv]
// ----------------------------------------------------------------------------
// Selector front end
// Accepts records, drops those of classes outside the table and marks the
// records whose cpu use passes the threshold.
// ----------------------------------------------------------------------------
module hfts_front #(
  parameter int CLASSES = hfts_pkg::HF_CLASSES
) (
  input  logic                         record_valid,
  output logic                         record_stall,
  input  logic [hfts_pkg::CLASS_W-1:0] class_index,
  input  logic [7:0]                   field_offset,
  input  logic [63:0]                  hotness,
  input  logic [31:0]                  cpu_use,
  input  logic                         first_record,
  input  logic                         last_record,
  input  logic [31:0]                  min_cpu_use,
  input  logic                         queue_full,
  output logic                         push,
  output hfts_pkg::item_t              push_item
);
  import hfts_pkg::*;

  logic in_range;

  assign in_range     = 32'(class_index) < 32'(CLASSES);
  assign record_stall = queue_full;
  assign push         = record_valid && !queue_full && in_range;

  always_comb begin
    push_item.class_index  = class_index;
    push_item.field_offset = field_offset;
    push_item.hotness      = hotness;
    push_item.consider     = cpu_use > min_cpu_use;
    push_item.first_record = first_record;
    push_item.last_record  = last_record;
  end

endmodule

[hw/rtl/hfts_queue.sv]
// ----------------------------------------------------------------------------
// Selector record queue
// Small flop-based queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module hfts_queue #(
  parameter int DEPTH = hfts_pkg::QUEUE_DEPTH,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  hfts_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output hfts_pkg::item_t head
);
  import hfts_pkg::*;

  item_t         entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = count == CW'(DEPTH);
  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

[hw/rtl/hfts_back.sv]
// ----------------------------------------------------------------------------
// Selector back end
// Reads the class table, runs the top-3, top-2 or top-1 selection and
// finalizes a list by writing the class back and loading the result word.
// ----------------------------------------------------------------------------
module hfts_back #(
  parameter int CLASSES = hfts_pkg::HF_CLASSES
) (
  input  logic                clk,
  input  logic                rst,
  input  hfts_pkg::back_cfg_t cfg,
  input  logic                head_valid,
  input  hfts_pkg::item_t     head,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [7:0]          hottest_offset,
  output logic [7:0]          second_offset,
  output logic [7:0]          third_offset,
  output logic [7:0]          repeat_count
);
  import hfts_pkg::*;

  localparam int TABLE_DEPTH = (CLASSES > MAX_TABLE) ? MAX_TABLE : CLASSES;
  localparam int TABLE_AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ENTRY_W     = $bits(entry_t);

  // Work stage registers.
  logic                   b_valid;
  item_t                  b_item;
  logic                   b_byp_hit;
  entry_t                 b_byp_data;
  logic                   b_entry_valid;
  logic [ENTRY_W-1:0]     ram_rdata;
  logic [TABLE_DEPTH-1:0] tbl_valid;

  // Running selection.
  offs_t run_offs;
  offs_t run_start;
  hot3_t top_hot;
  offs_t run_offs_next;
  offs_t run_start_next;
  hot3_t top_hot_next;
  logic [7:0] rep_next;

  entry_t              entry_raw;
  logic                entry_valid;
  offs_t               cur_offs;
  logic [7:0]          cur_rep;
  logic                active;
  logic                need_out;
  logic                out_free;
  logic                b_retire;
  logic                wr_en;
  logic [TABLE_AW-1:0] wr_addr;
  logic [TABLE_AW-1:0] rd_addr;
  entry_t              wr_data;
  logic [7:0]          rep_inc;

  hfts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (pop),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  // A write at the edge of the read is not seen by the RAM, so it is caught
  // in the bypass register. Entries never written read as the reset values.
  assign entry_raw   = b_byp_hit ? b_byp_data : entry_t'(ram_rdata);
  assign entry_valid = b_byp_hit || b_entry_valid;
  assign cur_offs    = entry_valid ? entry_raw.offs : {3{NO_FIELD}};
  assign cur_rep     = entry_valid ? entry_raw.repeats : 8'd0;

  assign active   = b_valid && (cur_rep != PERMANENT);
  assign need_out = active && b_item.last_record;
  assign out_free = !result_valid || !result_stall;
  assign b_retire = b_valid && (!need_out || out_free);
  assign pop      = head_valid && (!b_valid || b_retire);

  assign rd_addr = head.class_index[TABLE_AW-1:0];
  assign wr_addr = b_item.class_index[TABLE_AW-1:0];
  assign wr_en   = b_retire && need_out;
  assign rep_inc = cur_rep + 8'd1;

  always_comb begin
    run_start_next = b_item.first_record ? cur_offs : run_start;
    run_offs_next  = b_item.first_record ? cur_offs : run_offs;
    top_hot_next   = b_item.first_record ? '0 : top_hot;

    if (b_item.first_record && b_item.last_record) begin
      run_offs_next[0] = b_item.field_offset;
    end else begin
      if (b_item.consider) begin
        case (cfg.path_mode)
          MODE_THREE: begin
            if (b_item.hotness > top_hot_next[0]) begin
              top_hot_next[2]  = top_hot_next[1];
              run_offs_next[2] = run_offs_next[1];
              top_hot_next[1]  = top_hot_next[0];
              run_offs_next[1] = run_offs_next[0];
              top_hot_next[0]  = b_item.hotness;
              run_offs_next[0] = b_item.field_offset;
            end else if (b_item.hotness > top_hot_next[1]) begin
              top_hot_next[2]  = top_hot_next[1];
              run_offs_next[2] = run_offs_next[1];
              top_hot_next[1]  = b_item.hotness;
              run_offs_next[1] = b_item.field_offset;
            end else if (b_item.hotness > top_hot_next[2]) begin
              top_hot_next[2]  = b_item.hotness;
              run_offs_next[2] = b_item.field_offset;
            end
          end
          MODE_TWO: begin
            if (b_item.hotness > top_hot_next[0]) begin
              top_hot_next[1]  = top_hot_next[0];
              run_offs_next[1] = run_offs_next[0];
              top_hot_next[0]  = b_item.hotness;
              run_offs_next[0] = b_item.field_offset;
            end else if (b_item.hotness > top_hot_next[1]) begin
              top_hot_next[1]  = b_item.hotness;
              run_offs_next[1] = b_item.field_offset;
            end
          end
          default: begin
            if (b_item.hotness > top_hot_next[0]) begin
              top_hot_next[0]  = b_item.hotness;
              run_offs_next[0] = b_item.field_offset;
            end
          end
        endcase
      end
      if (b_item.last_record && (top_hot_next[2] < MIN_THIRD_HOTNESS)) begin
        run_offs_next[2] = NO_FIELD;
      end
    end

    // The stability counter only moves when permanence is enabled.
    rep_next = cur_rep;
    if (cfg.allow_permanent) begin
      if (run_offs_next == run_start_next) begin
        rep_next = (rep_inc == cfg.max_repeats) ? PERMANENT : rep_inc;
      end else begin
        rep_next = 8'd0;
      end
    end
  end

  always_comb begin
    wr_data.offs    = run_offs_next;
    wr_data.repeats = rep_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid      <= 1'b0;
      result_valid <= 1'b0;
      tbl_valid    <= '0;
      run_offs     <= '0;
      run_start    <= '0;
      top_hot      <= '0;
    end else begin
      if (pop) begin
        b_valid <= 1'b1;
      end else if (b_retire) begin
        b_valid <= 1'b0;
      end
      if (b_retire && active) begin
        run_offs  <= run_offs_next;
        run_start <= run_start_next;
        top_hot   <= top_hot_next;
      end
      if (wr_en) begin
        tbl_valid[wr_addr] <= 1'b1;
      end
      if (wr_en) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_item        <= head;
      b_byp_hit     <= wr_en && (wr_addr == rd_addr);
      b_byp_data    <= wr_data;
      b_entry_valid <= tbl_valid[rd_addr];
    end
    if (wr_en) begin
      hottest_offset <= run_offs_next[0];
      second_offset  <= run_offs_next[1];
      third_offset   <= run_offs_next[2];
      repeat_count   <= rep_next;
    end
  end

endmodule

[hw/rtl/hot_field_top3_selector.sv]
// ----------------------------------------------------------------------------
// Hot field top-3 selector
// Streams the field records of one class at a time and reports, at the end
// of each list, the hottest offsets and the class's stability counter.
// ----------------------------------------------------------------------------
// Usage:
// Records enter on the record channel (record_valid, record_stall); a record
// is taken at each edge where record_valid is high and record_stall is low.
// The block takes one record per cycle while record_stall is low. The rate is
// set by the single work stage, which reads the class table and updates the
// running top-3 slots.
// A result word appears on the result channel, registered, once the record
// marked last_record has passed the queue and the work stage. Only last
// records of classes in range and not yet permanent give a result word.
// When the receiver raises result_stall the result word holds; the work
// stage and the two-entry queue keep filling, and record_stall rises once
// the queue is full.
// Registers are to be written over the cfg port (cfg_valid, cfg_ready) while
// the block is idle, which it does not enforce; cfg_ready is always high.
// Reset clears the queue, the pipeline and the table valid bits, so every
// class reads as three empty slots and a zero counter; no clearing pass is
// needed.
// ----------------------------------------------------------------------------
module hot_field_top3_selector #(
  parameter int CLASSES     = hfts_pkg::HF_CLASSES,
  parameter int QUEUE_DEPTH = hfts_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         record_valid,
  output logic                         record_stall,
  input  logic [hfts_pkg::CLASS_W-1:0] class_index,
  input  logic [7:0]                   field_offset,
  input  logic [63:0]                  hotness,
  input  logic [31:0]                  cpu_use,
  input  logic                         first_record,
  input  logic                         last_record,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [7:0]                   hottest_offset,
  output logic [7:0]                   second_offset,
  output logic [7:0]                   third_offset,
  output logic [7:0]                   repeat_count,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);
  import hfts_pkg::*;

  logic [31:0] min_cpu_use;
  back_cfg_t   back_cfg;
  logic        push;
  item_t       push_item;
  logic        queue_full;
  logic        queue_not_empty;
  item_t       head;
  logic        pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_cpu_use              <= '0;
      back_cfg.path_mode       <= 2'd1;
      back_cfg.allow_permanent <= 1'b0;
      back_cfg.max_repeats     <= 8'hFF;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_CPU_USE:     min_cpu_use              <= cfg_data;
        REG_PATH_MODE:       back_cfg.path_mode       <= cfg_data[1:0];
        REG_ALLOW_PERMANENT: back_cfg.allow_permanent <= cfg_data[0];
        REG_MAX_REPEATS:     back_cfg.max_repeats     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  hfts_front #(
    .CLASSES (CLASSES)
  ) u_front (
    .record_valid (record_valid),
    .record_stall (record_stall),
    .class_index  (class_index),
    .field_offset (field_offset),
    .hotness      (hotness),
    .cpu_use      (cpu_use),
    .first_record (first_record),
    .last_record  (last_record),
    .min_cpu_use  (min_cpu_use),
    .queue_full   (queue_full),
    .push         (push),
    .push_item    (push_item)
  );

  hfts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_not_empty),
    .head      (head)
  );

  hfts_back #(
    .CLASSES (CLASSES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (back_cfg),
    .head_valid     (queue_not_empty),
    .head           (head),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .hottest_offset (hottest_offset),
    .second_offset  (second_offset),
    .third_offset   (third_offset),
    .repeat_count   (repeat_count)
  );

endmodule
